// ===== hdl/edpd_pkg.sv =====
// Shared types and constants for the packet deframer.
package edpd_pkg;

  // Most length bytes a packet header may carry
  localparam int unsigned MaxLenBytes = 4;

  localparam logic [7:0] PingTypeByte = 8'hD0;

  // Total lengths of the checked packet kinds
  localparam logic [28:0] ConnectTotal = 29'd4;
  localparam logic [28:0] CloseTotal   = 29'd3;
  localparam logic [28:0] PingTotal    = 29'd2;

  // Packet byte positions of the code byte, counting the type byte as 0
  localparam logic [2:0] ConnectCodePos = 3'd3;
  localparam logic [2:0] CloseCodePos   = 3'd2;

  // Register indexes
  localparam logic [1:0] CfgConnect = 2'd0;
  localparam logic [1:0] CfgClose   = 2'd1;
  localparam logic [1:0] CfgPing    = 2'd2;

  localparam logic [7:0] CfgConnectRst = 8'd32;
  localparam logic [7:0] CfgCloseRst   = 8'd64;
  localparam logic [7:0] CfgPingRst    = 8'd208;

  typedef enum logic [3:0] {
    ST_UNCHECKED   = 4'd0,
    ST_LEN_ERR     = 4'd1,
    ST_CONNECT_OK  = 4'd2,
    ST_AUTH_FAIL   = 4'd3,
    ST_CONNECT_BAD = 4'd4,
    ST_CLOSE       = 4'd5,
    ST_CLOSE_BAD   = 4'd6,
    ST_PING_OK     = 4'd7,
    ST_PING_BAD    = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] connect_code;
    logic [7:0] close_code;
    logic [7:0] ping_code;
  } cfg_t;

  // Result word, last field in the low bits
  typedef struct packed {
    logic [2:0]  payload_start;
    logic [28:0] pkt_bytes;
    logic [27:0] rem_bytes;
    logic [7:0]  ret_code;
    status_e     status;
    logic [7:0]  pkt_type;
  } result_t;

endpackage

// ===== hdl/edpd_classify.sv =====
// Length check and status code for a finished packet.
module edpd_classify (
  input  edpd_pkg::cfg_t    cfg_i,
  input  logic [7:0]        pkt_type_i,
  input  logic [28:0]       pkt_bytes_i,
  input  logic [7:0]        code_i,
  output edpd_pkg::status_e status_o,
  output logic [7:0]        ret_code_o
);

  always_comb begin
    status_o   = edpd_pkg::ST_UNCHECKED;
    ret_code_o = '0;
    // connect wins over close, close over ping when codes overlap
    priority if (pkt_type_i == cfg_i.connect_code) begin
      if (pkt_bytes_i == edpd_pkg::ConnectTotal) begin
        ret_code_o = code_i;
        status_o   = (code_i != '0) ? edpd_pkg::ST_AUTH_FAIL : edpd_pkg::ST_CONNECT_OK;
      end else begin
        status_o = edpd_pkg::ST_CONNECT_BAD;
      end
    end else if (pkt_type_i == cfg_i.close_code) begin
      if (pkt_bytes_i == edpd_pkg::CloseTotal) begin
        ret_code_o = code_i;
        status_o   = edpd_pkg::ST_CLOSE;
      end else begin
        status_o = edpd_pkg::ST_CLOSE_BAD;
      end
    end else if (pkt_type_i == cfg_i.ping_code) begin
      status_o = (pkt_bytes_i == edpd_pkg::PingTotal && pkt_type_i == edpd_pkg::PingTypeByte)
               ? edpd_pkg::ST_PING_OK : edpd_pkg::ST_PING_BAD;
    end else begin
      status_o = edpd_pkg::ST_UNCHECKED;
    end
  end

endmodule

// ===== hdl/edp_packet_deframer_top.sv =====
// Top level of the variable-length packet deframer.
// Timing: a byte is held in the input register before it is processed; the result word
//   is registered in the result register when the byte ending its packet is processed.
// Throughput: one byte per cycle; a result word held by m_axis_tready low stalls s_axis.
// Reset: rst_ni clears the handshake state and the framing phase, and loads the
//   type code registers with 32, 64 and 208.
module edp_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // received byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // finished packet reports
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [7:0] pkt_type, [11:8] status, [19:12] ret_code,
                                      // [47:20] remaining length, [76:48] total length,
                                      // [79:77] payload_start
);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  // ---------------------------------------------------------------------------
  // Type code registers
  // ---------------------------------------------------------------------------
  edpd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_code <= edpd_pkg::CfgConnectRst;
      cfg_q.close_code   <= edpd_pkg::CfgCloseRst;
      cfg_q.ping_code    <= edpd_pkg::CfgPingRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == edpd_pkg::CfgConnect) cfg_q.connect_code <= cfg_wdata_i;
      if (cfg_idx_i == edpd_pkg::CfgClose)   cfg_q.close_code   <= cfg_wdata_i;
      if (cfg_idx_i == edpd_pkg::CfgPing)    cfg_q.ping_code    <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and handshake
  // A byte in the input register is processed when the result register is
  // free or being drained this cycle.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  edpd_pkg::result_t out_q;
  logic       proc;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Framing state
  // ---------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [2:0]  len_cnt_q, len_cnt_d;
  logic [27:0] accum_q, accum_d;
  logic [27:0] left_q, left_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  code_q, code_d;

  logic [27:0] len_group;
  logic        emit_ok, emit_err;
  logic [28:0] pkt_bytes;
  logic        is_connect, is_close;
  edpd_pkg::status_e cls_status;
  logic [7:0]  cls_ret_code;

  assign is_connect = (type_q == cfg_q.connect_code);
  assign is_close   = (type_q == cfg_q.close_code);

  // 7-bit length group placed at its position, least significant group first
  always_comb begin
    unique case (len_cnt_q[1:0])
      2'd0:    len_group = {21'd0, in_byte_q[6:0]};
      2'd1:    len_group = {14'd0, in_byte_q[6:0], 7'd0};
      2'd2:    len_group = {7'd0, in_byte_q[6:0], 14'd0};
      default: len_group = {in_byte_q[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_cnt_d = len_cnt_q;
    accum_d   = accum_q;
    left_d    = left_q;
    idx_d     = idx_q;
    code_d    = code_q;
    emit_ok   = 1'b0;
    emit_err  = 1'b0;
    unique case (phase_q)
      PH_LEN: begin
        accum_d   = accum_q + len_group;
        len_cnt_d = len_cnt_q + 3'd1;
        if (idx_q != 3'd7) idx_d = idx_q + 3'd1;
        if (in_byte_q[7]) begin
          if (len_cnt_d >= 3'(edpd_pkg::MaxLenBytes)) begin
            emit_err = 1'b1;
            phase_d  = PH_TYPE;
          end
        end else if (accum_d == '0) begin
          // empty payload ends the packet here
          emit_ok = 1'b1;
          phase_d = PH_TYPE;
        end else begin
          left_d  = accum_d;
          phase_d = PH_PAY;
        end
      end
      PH_PAY: begin
        if (idx_q != 3'd7) idx_d = idx_q + 3'd1;
        priority if (is_connect) begin
          if (idx_d == edpd_pkg::ConnectCodePos) code_d = in_byte_q;
        end else if (is_close) begin
          if (idx_d == edpd_pkg::CloseCodePos) code_d = in_byte_q;
        end else begin
          code_d = code_q;
        end
        left_d = left_q - 28'd1;
        if (left_d == '0) begin
          emit_ok = 1'b1;
          phase_d = PH_TYPE;
        end
      end
      default: begin
        // type byte; the unused phase code lands here as well
        type_d    = in_byte_q;
        len_cnt_d = '0;
        accum_d   = '0;
        left_d    = '0;
        idx_d     = '0;
        code_d    = '0;
        phase_d   = PH_LEN;
      end
    endcase
  end

  assign pkt_bytes = {1'b0, accum_d} + {26'd0, len_cnt_d} + 29'd1;

  edpd_classify u_classify (
    .cfg_i       (cfg_q),
    .pkt_type_i  (type_q),
    .pkt_bytes_i (pkt_bytes),
    .code_i      (code_d),
    .status_o    (cls_status),
    .ret_code_o  (cls_ret_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
    end else if (proc) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      type_q    <= type_d;
      len_cnt_q <= len_cnt_d;
      accum_q   <= accum_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      code_q    <= code_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= emit_ok || emit_err;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && (emit_ok || emit_err)) begin
      out_q.pkt_type  <= type_q;
      out_q.rem_bytes <= accum_d;
      if (emit_err) begin
        out_q.status        <= edpd_pkg::ST_LEN_ERR;
        out_q.ret_code      <= '0;
        out_q.pkt_bytes     <= '0;
        out_q.payload_start <= '0;
      end else begin
        out_q.status        <= cls_status;
        out_q.ret_code      <= cls_ret_code;
        out_q.pkt_bytes     <= pkt_bytes;
        out_q.payload_start <= len_cnt_d + 3'd1;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  // A good packet's total length is its remaining length plus the header
  a_pkt_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != edpd_pkg::ST_LEN_ERR) |->
      (out_q.pkt_bytes == {1'b0, out_q.rem_bytes} + {26'd0, out_q.payload_start}))
    else $error("total length does not match remaining length plus header");

  // A length overflow report carries no length or offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == edpd_pkg::ST_LEN_ERR) |->
      (out_q.pkt_bytes == '0 && out_q.payload_start == '0 && out_q.ret_code == '0))
    else $error("length error report with nonzero fields");

  // Payload phase always has bytes still to come
  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (left_q != '0))
    else $error("payload phase with nothing left");

  // Length byte count never runs past the limit
  a_len_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN) |-> (len_cnt_q < 3'(edpd_pkg::MaxLenBytes)))
    else $error("length byte count past limit");
`endif

endmodule
